FILE: src/sftr_pkg.sv
// Shared types, constants and tables of the scaled 5x7 character generator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package sftr_pkg;

    localparam int MAX_CHARS  = 32;
    localparam int LINE_WIDTH = 410;
    localparam int MAX_SCALE  = 8;
    localparam int POS_W      = $clog2(MAX_CHARS);
    localparam int LEN_W      = POS_W + 1;
    localparam int GLYPH_W    = 6;
    localparam int PX_W       = 9;
    localparam int PY_W       = 7;
    localparam int SCALE_W    = 4;
    localparam int COLOR_W    = 16;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SH   = 16;
    localparam int FC_W       = 9;
    localparam int CI_W       = 7;
    localparam int COL_W      = 3;
    localparam int DIV6_MUL   = 683;
    localparam int DIV6_SH    = 12;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;

    localparam logic [GLYPH_W-1:0] G_SPACE = 6'd0;
    localparam logic [GLYPH_W-1:0] G_ALPHA = 6'd1;
    localparam logic [GLYPH_W-1:0] G_DIGIT = 6'd27;
    localparam logic [GLYPH_W-1:0] G_COLON = 6'd37;
    localparam logic [GLYPH_W-1:0] G_DASH  = 6'd38;
    localparam logic [GLYPH_W-1:0] G_DOT   = 6'd39;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_SCALE    = 2'd0,
        REG_X_ORIGIN = 2'd1,
        REG_FG_COLOR = 2'd2,
        REG_BG_COLOR = 2'd3
    } t_reg;

    typedef struct packed {
        t_op                op;
        logic [POS_W-1:0]   pos;
        logic [GLYPH_W-1:0] glyph;
        logic               term;
        logic [PX_W-1:0]    dx;
        logic [PY_W-1:0]    py;
        logic               outside;
    } t_item;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [PX_W-1:0]    x_origin;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
    } t_cfg;

    localparam logic [6:0] GLYPH_ROM [0:39][0:4] = '{
        '{7'h00,7'h00,7'h00,7'h00,7'h00},
        '{7'h7E,7'h11,7'h11,7'h11,7'h7E}, '{7'h7F,7'h49,7'h49,7'h49,7'h36},
        '{7'h3E,7'h41,7'h41,7'h41,7'h22}, '{7'h7F,7'h41,7'h41,7'h22,7'h1C},
        '{7'h7F,7'h49,7'h49,7'h49,7'h41}, '{7'h7F,7'h09,7'h09,7'h09,7'h01},
        '{7'h3E,7'h41,7'h49,7'h49,7'h7A}, '{7'h7F,7'h08,7'h08,7'h08,7'h7F},
        '{7'h41,7'h41,7'h7F,7'h41,7'h41}, '{7'h20,7'h40,7'h41,7'h3F,7'h01},
        '{7'h7F,7'h08,7'h14,7'h22,7'h41}, '{7'h7F,7'h40,7'h40,7'h40,7'h40},
        '{7'h7F,7'h02,7'h0C,7'h02,7'h7F}, '{7'h7F,7'h04,7'h08,7'h10,7'h7F},
        '{7'h3E,7'h41,7'h41,7'h41,7'h3E}, '{7'h7F,7'h09,7'h09,7'h09,7'h06},
        '{7'h3E,7'h41,7'h51,7'h21,7'h5E}, '{7'h7F,7'h09,7'h19,7'h29,7'h46},
        '{7'h46,7'h49,7'h49,7'h49,7'h31}, '{7'h01,7'h01,7'h7F,7'h01,7'h01},
        '{7'h3F,7'h40,7'h40,7'h40,7'h3F}, '{7'h1F,7'h20,7'h40,7'h20,7'h1F},
        '{7'h7F,7'h20,7'h18,7'h20,7'h7F}, '{7'h63,7'h14,7'h08,7'h14,7'h63},
        '{7'h07,7'h08,7'h70,7'h08,7'h07}, '{7'h61,7'h51,7'h49,7'h45,7'h43},
        '{7'h3E,7'h51,7'h49,7'h45,7'h3E}, '{7'h00,7'h42,7'h7F,7'h40,7'h00},
        '{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4B,7'h31},
        '{7'h18,7'h14,7'h12,7'h7F,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
        '{7'h3C,7'h4A,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
        '{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1E},
        '{7'h00,7'h36,7'h36,7'h00,7'h00}, '{7'h08,7'h08,7'h08,7'h08,7'h08},
        '{7'h00,7'h60,7'h60,7'h00,7'h00}
    };

    function automatic logic [GLYPH_W-1:0] code_to_glyph(input logic [7:0] code);
        logic [GLYPH_W-1:0] g;
        g = G_SPACE;
        if (code >= 8'h41 && code <= 8'h5A) begin
            g = G_ALPHA + GLYPH_W'(code - 8'h41);
        end else if (code >= 8'h30 && code <= 8'h39) begin
            g = G_DIGIT + GLYPH_W'(code - 8'h30);
        end else if (code == 8'h3A) begin
            g = G_COLON;
        end else if (code == 8'h2D) begin
            g = G_DASH;
        end else if (code == 8'h2E) begin
            g = G_DOT;
        end
        return g;
    endfunction

    // floor(2^16 / s) + 1, exact quotient for 9-bit dividends
    function automatic logic [RECIP_W-1:0] scale_recip(input logic [SCALE_W-1:0] s);
        logic [RECIP_W-1:0] r;
        case (s)
            4'd1:    r = 17'd65537;
            4'd2:    r = 17'd32769;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16385;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8193;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/sftr_front.sv
// Front end: takes stream items, maps character codes to glyphs and
// offsets query columns against the origin. Depends on sftr_pkg.
`default_nettype none
module sftr_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [31:0]           i_s_tdata,
    input  wire logic                  i_s_tuser,
    input  wire logic [sftr_pkg::PX_W-1:0] i_x_origin,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output sftr_pkg::t_item            o_item
);

    logic [sftr_pkg::POS_W-1:0] w_pos;
    logic [7:0]                 w_code;
    logic [sftr_pkg::PX_W-1:0]  w_px;
    logic [sftr_pkg::PY_W-1:0]  w_py;
    logic [sftr_pkg::PX_W-1:0]  w_x0;
    logic                       r_ready;

    assign w_pos  = i_s_tdata[4:0];
    assign w_code = i_s_tdata[12:5];
    assign w_px   = i_s_tdata[21:13];
    assign w_py   = i_s_tdata[28:22];
    assign w_x0   = {i_x_origin[sftr_pkg::PX_W-1:1], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign o_s_tready = r_ready && !i_q_full;
    assign o_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_item.op      = sftr_pkg::t_op'(i_s_tuser);
        o_item.pos     = w_pos;
        o_item.glyph   = sftr_pkg::code_to_glyph(w_code);
        o_item.term    = (w_code == 8'd0);
        o_item.dx      = w_px - w_x0;
        o_item.py      = w_py;
        o_item.outside = (w_px >= sftr_pkg::PX_W'(sftr_pkg::LINE_WIDTH)) || (w_px < w_x0);
    end

endmodule
`default_nettype wire

FILE: src/sftr_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on sftr_pkg for the item type.
`default_nettype none
module sftr_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sftr_pkg::t_item  i_item,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output sftr_pkg::t_item       o_item
);

    sftr_pkg::t_item r_mem [0:1];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/sftr_back.sv
// Back end: executes stores into the glyph store and resolves pixel queries
// through scale division, cell split, glyph lookup and color choice.
// Depends on sftr_pkg.
`default_nettype none
module sftr_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sftr_pkg::t_cfg   i_cfg,
    input  wire logic             i_q_empty,
    input  wire sftr_pkg::t_item  i_item,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [15:0]           o_m_tdata,
    output logic                  o_m_tuser
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [sftr_pkg::GLYPH_W-1:0]    r_store [0:sftr_pkg::MAX_CHARS-1];
    logic [sftr_pkg::LEN_W-1:0]      r_text_len;
    logic [sftr_pkg::FC_W-1:0]       r_fc;
    logic [sftr_pkg::PY_W-1:0]       r_row;
    logic                            r_off;
    logic [sftr_pkg::GLYPH_W-1:0]    r_glyph;
    logic [sftr_pkg::COL_W-1:0]      r_col;
    logic                            r_hit;
    logic                            r_out_valid;
    logic [15:0]                     r_out_color;
    logic                            r_out_fg;

    logic [sftr_pkg::SCALE_W-1:0]    w_scale;
    logic [sftr_pkg::RECIP_W-1:0]    w_recip;
    logic [25:0]                     w_dx_prod;
    logic [23:0]                     w_py_prod;
    logic [18:0]                     w_div6;
    logic [sftr_pkg::CI_W-1:0]       w_ci;
    logic [8:0]                      w_ci_x6;
    logic [8:0]                      w_col_full;
    logic [sftr_pkg::COL_W-1:0]      w_col;
    logic                            w_is_store;
    logic                            w_out_free;
    logic [6:0]                      w_bits;
    logic                            w_on;
    logic [15:0]                     w_color;
    logic [sftr_pkg::LEN_W-1:0]      w_pos_next;
    logic [sftr_pkg::LEN_W-1:0]      n_text_len;

    assign w_scale = (i_cfg.scale > sftr_pkg::SCALE_W'(sftr_pkg::MAX_SCALE))
                   ? sftr_pkg::SCALE_W'(sftr_pkg::MAX_SCALE) : i_cfg.scale;
    assign w_recip   = sftr_pkg::scale_recip(w_scale);
    assign w_dx_prod = 26'(i_item.dx) * 26'(w_recip);
    assign w_py_prod = 24'(i_item.py) * 24'(w_recip);

    assign w_div6     = 19'(r_fc) * 19'(sftr_pkg::DIV6_MUL);
    assign w_ci       = w_div6[18:sftr_pkg::DIV6_SH];
    assign w_ci_x6    = {w_ci, 2'b00} + {1'b0, w_ci, 1'b0};
    assign w_col_full = r_fc - w_ci_x6;
    assign w_col      = w_col_full[sftr_pkg::COL_W-1:0];

    assign w_bits  = sftr_pkg::GLYPH_ROM[r_glyph][r_col];
    assign w_on    = r_hit && w_bits[r_row[2:0]];
    assign w_color = w_on ? i_cfg.fg_color : i_cfg.bg_color;

    assign w_is_store = (i_item.op == sftr_pkg::OP_STORE);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;

    assign w_pos_next = sftr_pkg::LEN_W'(i_item.pos) + sftr_pkg::LEN_W'(1);

    always_comb begin
        n_text_len = r_text_len;
        if (i_item.term) begin
            n_text_len = sftr_pkg::LEN_W'(i_item.pos);
        end else if (w_pos_next > r_text_len) begin
            n_text_len = w_pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_is_store && !i_item.term) begin
            r_store[i_item.pos] <= i_item.glyph;
        end
        if (r_state == S_SPLIT) begin
            r_glyph <= r_store[w_ci[sftr_pkg::POS_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_text_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (w_is_store) begin
                            r_text_len <= n_text_len;
                        end else begin
                            r_fc    <= w_dx_prod[sftr_pkg::RECIP_SH +: sftr_pkg::FC_W];
                            r_row   <= w_py_prod[sftr_pkg::RECIP_SH +: sftr_pkg::PY_W];
                            r_off   <= i_item.outside || (w_scale == '0);
                            r_state <= S_SPLIT;
                        end
                    end
                end
                S_SPLIT: begin
                    r_col   <= (w_col < sftr_pkg::COL_W'(sftr_pkg::GLYPH_COLS)) ? w_col : '0;
                    r_hit   <= !r_off
                            && (w_ci < sftr_pkg::CI_W'(r_text_len))
                            && (w_col < sftr_pkg::COL_W'(sftr_pkg::GLYPH_COLS))
                            && (r_row < sftr_pkg::PY_W'(sftr_pkg::GLYPH_ROWS));
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_color <= {w_color[7:0], w_color[15:8]};
                        r_out_fg    <= w_on;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_color;
    assign o_m_tuser  = r_out_fg;

endmodule
`default_nettype wire

FILE: src/scaled_font_text_rasterizer_core.sv
// Top level of the scaled 5x7 character generator: configuration registers,
// front end, item queue and back end. Depends on sftr_pkg, sftr_front,
// sftr_queue and sftr_back.
//
// Store items (tuser 0) write one character into a 32-entry string, or with
// code zero set its length to their position; pixel queries (tuser 1) pass
// through scale division by reciprocal multiply, cell and column split with
// glyph store read, font lookup and color choice, and return one result each.
// A two-entry queue lets the input keep accepting while the back end works,
// and the output register holds a result until the sink takes it. Entries of
// the string that were never written read back as undefined glyphs.
`default_nettype none
module scaled_font_text_rasterizer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // char_pos[4:0], char_code[12:5], pixel_x[21:13], pixel_y[28:22], zero pad
    input  wire logic [31:0] i_s_tdata,
    // opcode
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // pixel_color[15:0]
    output logic [15:0]      o_m_tdata,
    // is_foreground
    output logic             o_m_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    sftr_pkg::t_cfg  r_cfg;
    logic            r_cfg_ready;
    sftr_pkg::t_item w_push_item;
    sftr_pkg::t_item w_pop_item;
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready    <= 1'b0;
            r_cfg.scale    <= 4'd4;
            r_cfg.x_origin <= 9'd72;
            r_cfg.fg_color <= 16'd63355;
            r_cfg.bg_color <= 16'd10564;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                case (sftr_pkg::t_reg'(i_cfg_index))
                    sftr_pkg::REG_SCALE:    r_cfg.scale    <= i_cfg_data[3:0];
                    sftr_pkg::REG_X_ORIGIN: r_cfg.x_origin <= i_cfg_data[8:0];
                    sftr_pkg::REG_FG_COLOR: r_cfg.fg_color <= i_cfg_data;
                    sftr_pkg::REG_BG_COLOR: r_cfg.bg_color <= i_cfg_data;
                    default: begin
                        r_cfg <= r_cfg;
                    end
                endcase
            end
        end
    end

    assign o_cfg_ready = r_cfg_ready;

    sftr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_x_origin (r_cfg.x_origin),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    sftr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    sftr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (w_empty),
        .i_item     (w_pop_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire
